FILE: design/imgf_pkg.sv
// ----------------------------------------------------------------------------
// imgf_pkg
// Shared types and constants of the interval merge and gap finder.
// ----------------------------------------------------------------------------
package imgf_pkg;

    localparam int OFF_W      = 48;
    localparam int ALIGN_W    = 33;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 48;
    localparam int DIV_STEPS  = 48;
    localparam int STEP_W     = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_FILE_SIZE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_ALIGN = 8'd1;

    localparam logic [1:0] OUTC_GAP      = 2'd0;
    localparam logic [1:0] OUTC_NO_GAP   = 2'd1;
    localparam logic [1:0] OUTC_TRUNC    = 2'd2;
    localparam logic [1:0] OUTC_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [OFF_W-1:0] range_offset;
        logic [OFF_W-1:0] range_length;
        logic             final_range;
    } in_item_t;

    typedef struct packed {
        logic [OFF_W-1:0] gap_start;
        logic [OFF_W-1:0] gap_length;
        logic [OFF_W-1:0] unused_total;
        logic [1:0]       outcome;
        logic             end_of_report;
    } out_item_t;

    typedef struct packed {
        logic [OFF_W-1:0] off;
        logic [OFF_W-1:0] len;
    } span_t;

    // insert: sorted insertion of the key; shift: row moves toward cell 0
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_cmd_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CHECK,
        ST_SCAN,
        ST_DIV,
        ST_TAIL,
        ST_LAST
    } state_t;

endpackage

FILE: design/imgf_cell.sv
// ----------------------------------------------------------------------------
// imgf_cell
// One slot of the sorted range row: insertion from the left, drain to cell 0.
// ----------------------------------------------------------------------------
module imgf_cell (
    input  logic                aclk,
    input  imgf_pkg::cell_cmd_t cmd,
    input  logic                slot_valid,
    input  imgf_pkg::span_t     key,
    input  imgf_pkg::span_t     prev_data,
    input  logic                prev_after,
    input  imgf_pkg::span_t     next_data,
    output imgf_pkg::span_t     data,
    output logic                after
);

    imgf_pkg::span_t data_reg;
    imgf_pkg::span_t data_next;

    // key belongs at or before this slot
    assign after = !slot_valid || (key.off < data_reg.off);
    assign data  = data_reg;

    always_comb begin
        data_next = data_reg;
        if (cmd.insert) begin
            if (prev_after) begin
                data_next = prev_data;
            end else if (after) begin
                data_next = key;
            end
        end else if (cmd.shift) begin
            data_next = next_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

FILE: design/interval_merge_gap_finder_top.sv
// Ranges load one per cycle. After the final range is taken, an overflow or truncated
// report is issued from the check state once the output is free; otherwise the check,
// scan, divider, tail and close states run in that order up to the last result.
// No input is taken during a report.
// The bit-serial remainder unit sets the tail cost. Reset (aresetn low, synchronous)
// empties the row, clears the overflow flag, sets the file size to 0 and alignment to 1.
// ----------------------------------------------------------------------------
// interval_merge_gap_finder_top
// Sorts used ranges of a file in a cell row, then reports gaps and the tail gap.
// ----------------------------------------------------------------------------
module interval_merge_gap_finder_top #(
    parameter int MAX_RANGES = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  imgf_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output imgf_pkg::out_item_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [imgf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [imgf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int W  = imgf_pkg::OFF_W;
    localparam int AW = imgf_pkg::ALIGN_W;

    // configuration registers
    logic [W-1:0]  fsize_reg;
    logic [AW-1:0] tail_align_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsize_reg      <= '0;
            tail_align_reg <= AW'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                imgf_pkg::CFG_FILE_SIZE:  fsize_reg      <= cfg_data[W-1:0];
                imgf_pkg::CFG_TAIL_ALIGN: tail_align_reg <= cfg_data[AW-1:0];
                default: ;
            endcase
        end
    end

    // control and datapath state
    imgf_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic [W:0]          max_end_reg, max_end_next;
    logic [W:0]          pos_reg, pos_next;
    logic [W-1:0]        total_reg, total_next;
    logic                pend_valid_reg, pend_valid_next;
    imgf_pkg::out_item_t pend_reg, pend_next;
    logic [AW-1:0]       rem_reg, rem_next;
    logic [W-1:0]        div_reg, div_next;
    logic [imgf_pkg::STEP_W-1:0] step_reg, step_next;
    logic                out_valid_reg;
    imgf_pkg::out_item_t out_reg, out_next;
    logic                emit;

    // cell row
    imgf_pkg::cell_cmd_t cmd;
    imgf_pkg::span_t     key;
    imgf_pkg::span_t     cell_data [MAX_RANGES];
    logic [MAX_RANGES-1:0] cell_after;

    assign key.off = s_data.range_offset;
    assign key.len = s_data.range_length;

    for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
        imgf_pkg::span_t prev_d;
        imgf_pkg::span_t next_d;
        logic            prev_a;
        if (i == 0) begin : g_first
            assign prev_d = key;
            assign prev_a = 1'b0;
        end else begin : g_mid
            assign prev_d = cell_data[i-1];
            assign prev_a = cell_after[i-1];
        end
        if (i == MAX_RANGES - 1) begin : g_last
            assign next_d = cell_data[i];
        end else begin : g_inner
            assign next_d = cell_data[i+1];
        end
        imgf_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .slot_valid (CW'(i) < count_reg),
            .key        (key),
            .prev_data  (prev_d),
            .prev_after (prev_a),
            .next_data  (next_d),
            .data       (cell_data[i]),
            .after      (cell_after[i])
        );
    end

    // shared combinational terms
    logic            out_free;
    logic            full;
    logic [W:0]      in_end;
    logic [W:0]      head_end;
    logic            head_gap;
    logic [W-1:0]    head_gap_len;
    logic [AW-1:0]   align_eff;
    logic [AW:0]     rem_sh;
    logic [W:0]      round_end;
    logic            tail_gap;
    logic [W-1:0]    tail_len;
    logic            in_take;

    assign out_free     = !out_valid_reg || m_ready;
    assign full         = (count_reg == CW'(MAX_RANGES));
    assign in_take      = s_valid && s_ready;
    assign in_end       = {1'b0, s_data.range_offset} + {1'b0, s_data.range_length};
    assign head_end     = {1'b0, cell_data[0].off} + {1'b0, cell_data[0].len};
    assign head_gap     = {1'b0, cell_data[0].off} > pos_reg;
    assign head_gap_len = cell_data[0].off - pos_reg[W-1:0];
    assign align_eff    = (tail_align_reg == '0) ? AW'(1) : tail_align_reg;
    assign rem_sh       = {rem_reg, div_reg[W-1]};
    // round up: add the distance from the remainder to the next multiple
    assign round_end    = {1'b0, pos_reg[W-1:0]}
                        + ((rem_reg != '0) ? (W+1)'(align_eff - rem_reg) : '0);
    assign tail_gap     = round_end < {1'b0, fsize_reg};
    assign tail_len     = fsize_reg - round_end[W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            imgf_pkg::ST_LOAD: begin
                if (in_take && s_data.final_range) state_next = imgf_pkg::ST_CHECK;
            end
            imgf_pkg::ST_CHECK: begin
                if (ovf_reg || (count_reg != '0 && max_end_reg > {1'b0, fsize_reg})) begin
                    if (out_free) state_next = imgf_pkg::ST_LOAD;
                end else begin
                    state_next = imgf_pkg::ST_SCAN;
                end
            end
            imgf_pkg::ST_SCAN: begin
                if (count_reg == '0) state_next = imgf_pkg::ST_DIV;
            end
            imgf_pkg::ST_DIV: begin
                if (step_reg == imgf_pkg::STEP_W'(imgf_pkg::DIV_STEPS - 1))
                    state_next = imgf_pkg::ST_TAIL;
            end
            imgf_pkg::ST_TAIL: begin
                if (!(tail_gap && pend_valid_reg && !out_free))
                    state_next = imgf_pkg::ST_LAST;
            end
            imgf_pkg::ST_LAST: begin
                if (out_free) state_next = imgf_pkg::ST_LOAD;
            end
            default: state_next = imgf_pkg::ST_LOAD;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_ready         = 1'b0;
        cmd             = '0;
        emit            = 1'b0;
        out_next        = out_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        max_end_next    = max_end_reg;
        pos_next        = pos_reg;
        total_next      = total_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        step_next       = step_reg;
        case (state_reg)
            imgf_pkg::ST_LOAD: begin
                s_ready = 1'b1;
                if (in_take) begin
                    if (full) begin
                        ovf_next = 1'b1;
                    end else begin
                        cmd.insert = 1'b1;
                        count_next = count_reg + CW'(1);
                        if (count_reg == '0 || in_end > max_end_reg) max_end_next = in_end;
                    end
                end
            end
            imgf_pkg::ST_CHECK: begin
                pos_next        = '0;
                total_next      = '0;
                pend_valid_next = 1'b0;
                if (ovf_reg || (count_reg != '0 && max_end_reg > {1'b0, fsize_reg})) begin
                    if (out_free) begin
                        emit                   = 1'b1;
                        out_next               = '0;
                        out_next.outcome       = ovf_reg ? imgf_pkg::OUTC_OVERFLOW
                                                         : imgf_pkg::OUTC_TRUNC;
                        out_next.end_of_report = 1'b1;
                        count_next             = '0;
                        ovf_next               = 1'b0;
                    end
                end
            end
            imgf_pkg::ST_SCAN: begin
                if (count_reg == '0) begin
                    div_next  = pos_reg[W-1:0];
                    rem_next  = '0;
                    step_next = '0;
                end else if (!(head_gap && pend_valid_reg && !out_free)) begin
                    if (head_gap) begin
                        if (pend_valid_reg) begin
                            emit     = 1'b1;
                            out_next = pend_reg;
                        end
                        pend_valid_next        = 1'b1;
                        pend_next.gap_start    = pos_reg[W-1:0];
                        pend_next.gap_length   = head_gap_len;
                        pend_next.unused_total = total_reg + head_gap_len;
                        pend_next.outcome      = imgf_pkg::OUTC_GAP;
                        pend_next.end_of_report = 1'b0;
                        total_next             = total_reg + head_gap_len;
                    end
                    if (head_end > pos_reg) pos_next = head_end;
                    cmd.shift  = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            imgf_pkg::ST_DIV: begin
                // one quotient bit per cycle, only the remainder is kept
                div_next  = {div_reg[W-2:0], 1'b0};
                step_next = step_reg + imgf_pkg::STEP_W'(1);
                if (rem_sh >= {1'b0, align_eff}) begin
                    rem_next = AW'(rem_sh - {1'b0, align_eff});
                end else begin
                    rem_next = rem_sh[AW-1:0];
                end
            end
            imgf_pkg::ST_TAIL: begin
                if (tail_gap && !(pend_valid_reg && !out_free)) begin
                    if (pend_valid_reg) begin
                        emit     = 1'b1;
                        out_next = pend_reg;
                    end
                    pend_valid_next         = 1'b1;
                    pend_next.gap_start     = round_end[W-1:0];
                    pend_next.gap_length    = tail_len;
                    pend_next.unused_total  = total_reg + tail_len;
                    pend_next.outcome       = imgf_pkg::OUTC_GAP;
                    pend_next.end_of_report = 1'b0;
                    total_next              = total_reg + tail_len;
                end
            end
            imgf_pkg::ST_LAST: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (pend_valid_reg) begin
                        out_next = pend_reg;
                    end else begin
                        out_next         = '0;
                        out_next.outcome = imgf_pkg::OUTC_NO_GAP;
                    end
                    out_next.end_of_report = 1'b1;
                    pend_valid_next        = 1'b0;
                    count_next             = '0;
                    ovf_next               = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= imgf_pkg::ST_LOAD;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            step_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            step_reg       <= step_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        max_end_reg <= max_end_next;
        pos_reg     <= pos_next;
        total_reg   <= total_next;
        pend_reg    <= pend_next;
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        out_reg     <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_RANGES))
        else $error("range count above capacity");

    a_report_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && out_next.end_of_report |=> state_reg == imgf_pkg::ST_LOAD && count_reg == '0)
        else $error("report closed without returning to load");

    a_load_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pend_valid_reg)
        else $error("pending gap left over while loading");

    a_row_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == imgf_pkg::ST_SCAN && count_reg >= CW'(2)
            |-> cell_data[0].off <= cell_data[1].off)
        else $error("cell row out of order");
`endif

endmodule
